// File: rtl/ckm_pkg.sv
// ckm_pkg: shared constants and types for the chroma key matte pipeline
// no dependencies; imported by ckm_ycc, ckm_sqrt, ckm_div and chroma_key_matte
package ckm_pkg;

    localparam int LATENCY = 18;
    localparam int KEY_DLY = 7;
    localparam int SEL_DLY = 4;

    localparam logic [14:0] CY_R = 15'd6966;
    localparam logic [14:0] CY_G = 15'd23436;
    localparam logic [14:0] CY_B = 15'd2366;
    localparam logic [14:0] C_CB = 15'd17659;
    localparam logic [14:0] C_CR = 15'd20808;
    localparam logic [23:0] RECIP_255 = 24'd8421505;
    localparam logic [15:0] Q_ONE = 16'd32768;

    localparam logic [2:0] REG_KEY_RED    = 3'd0;
    localparam logic [2:0] REG_KEY_GREEN  = 3'd1;
    localparam logic [2:0] REG_KEY_BLUE   = 3'd2;
    localparam logic [2:0] REG_CHROMA_SPR = 3'd3;
    localparam logic [2:0] REG_CHROMA_TOL = 3'd4;
    localparam logic [2:0] REG_LUMA_SPR   = 3'd5;

    typedef logic [2:0] cfg_idx_t;

    typedef enum logic [1:0] {
        FAC_ZERO = 2'd0,
        FAC_RAMP = 2'd1,
        FAC_FULL = 2'd2
    } fac_sel_t;

    typedef struct packed {
        fac_sel_t chroma;
        fac_sel_t luma;
    } fac_ctl_t;

endpackage

// File: rtl/ckm_ycc.sv
// ckm_ycc: four-stage rgb to luma and scaled cb/cr conversion, q1.15
// depends on ckm_pkg for the color coefficients
module ckm_ycc (
    input  logic               aclk,
    input  logic               en,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    output logic [15:0]        luma,
    output logic signed [15:0] cb,
    output logic signed [15:0] cr
);
    import ckm_pkg::*;

    logic [22:0] ysum_reg, bsum_reg, rsum_reg;
    logic [22:0] ysum_next, bsum_next, rsum_next;
    logic [46:0] yprod, bprod, rprod;
    logic [15:0] y1_reg, bn_reg, rn_reg;
    logic signed [16:0] bdiff, rdiff, bneg, rneg;
    logic [15:0] bmag, rmag;
    logic [15:0] y2_reg;
    logic [30:0] cbp_reg, crp_reg, cbp_next, crp_next;
    logic        cbneg_reg, crneg_reg;
    logic [30:0] cbr, crr;
    logic [15:0] cbq, crq;
    logic [15:0] y3_reg;
    logic signed [15:0] cb_reg, cr_reg, cb_next, cr_next;

    // stage 1: weighted sums and scaled channels
    assign ysum_next = 23'(CY_R) * 23'(red) + 23'(CY_G) * 23'(green)
                     + 23'(CY_B) * 23'(blue) + 23'd127;
    assign bsum_next = {blue, 15'd0} + 23'd127;
    assign rsum_next = {red, 15'd0} + 23'd127;

    // stage 2: divide by 255 through reciprocal
    assign yprod = {24'd0, ysum_reg} * {23'd0, RECIP_255};
    assign bprod = {24'd0, bsum_reg} * {23'd0, RECIP_255};
    assign rprod = {24'd0, rsum_reg} * {23'd0, RECIP_255};

    // stage 3: color difference magnitude times chroma scale
    assign bdiff = $signed({1'b0, bn_reg}) - $signed({1'b0, y1_reg});
    assign rdiff = $signed({1'b0, rn_reg}) - $signed({1'b0, y1_reg});
    assign bneg  = -bdiff;
    assign rneg  = -rdiff;
    assign bmag  = bdiff[16] ? bneg[15:0] : bdiff[15:0];
    assign rmag  = rdiff[16] ? rneg[15:0] : rdiff[15:0];
    assign cbp_next = 31'(bmag) * 31'(C_CB);
    assign crp_next = 31'(rmag) * 31'(C_CR);

    // stage 4: round half away from zero
    assign cbr = cbp_reg + 31'd16384;
    assign crr = crp_reg + 31'd16384;
    assign cbq = cbr[30:15];
    assign crq = crr[30:15];
    assign cb_next = cbneg_reg ? $signed(16'd0 - cbq) : $signed(cbq);
    assign cr_next = crneg_reg ? $signed(16'd0 - crq) : $signed(crq);

    always_ff @(posedge aclk) begin
        if (en) begin
            ysum_reg  <= ysum_next;
            bsum_reg  <= bsum_next;
            rsum_reg  <= rsum_next;
            y1_reg    <= yprod[46:31];
            bn_reg    <= bprod[46:31];
            rn_reg    <= rprod[46:31];
            y2_reg    <= y1_reg;
            cbp_reg   <= cbp_next;
            crp_reg   <= crp_next;
            cbneg_reg <= bdiff[16];
            crneg_reg <= rdiff[16];
            y3_reg    <= y2_reg;
            cb_reg    <= cb_next;
            cr_reg    <= cr_next;
        end
    end

    assign luma = y3_reg;
    assign cb   = cb_reg;
    assign cr   = cr_reg;

endmodule

// File: rtl/ckm_sqrt.sv
// ckm_sqrt: five-stage rounded square root of a 32-bit value, four digits per stage
// depends on ckm_pkg
module ckm_sqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] radicand,
    output logic [16:0] root
);
    import ckm_pkg::*;

    logic [31:0] rem_reg [4];
    logic [31:0] res_reg [4];
    logic [16:0] root_reg, root_next;

    for (genvar g = 0; g < 4; g++) begin : g_stage
        logic [31:0] rem_in, res_in, rem_next, res_next, trial, bitv;
        if (g == 0) begin : g_first
            assign rem_in = radicand;
            assign res_in = '0;
        end else begin : g_more
            assign rem_in = rem_reg[g-1];
            assign res_in = res_reg[g-1];
        end
        always_comb begin
            rem_next = rem_in;
            res_next = res_in;
            trial    = '0;
            bitv     = '0;
            for (int j = 0; j < 4; j++) begin
                bitv  = 32'd1 << (30 - 2 * (4 * g + j));
                trial = res_next + bitv;
                if (rem_next >= trial) begin
                    rem_next = rem_next - trial;
                    res_next = (res_next >> 1) + bitv;
                end else begin
                    res_next = res_next >> 1;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= rem_next;
                res_reg[g] <= res_next;
            end
        end
    end

    // round to nearest
    assign root_next = res_reg[3][16:0] + {16'd0, (rem_reg[3] > res_reg[3])};

    always_ff @(posedge aclk) begin
        if (en) begin
            root_reg <= root_next;
        end
    end

    assign root = root_reg;

endmodule

// File: rtl/ckm_div.sv
// ckm_div: four-stage restoring divider, 16-bit quotient, four bits per stage
// depends on ckm_pkg; quotient must be below 2^16
module ckm_div (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] num,
    input  logic [15:0] den,
    output logic [15:0] quot
);
    import ckm_pkg::*;

    logic [31:0] rem_reg [3];
    logic [15:0] den_reg [3];
    logic [15:0] q_reg   [4];

    for (genvar g = 0; g < 4; g++) begin : g_stage
        logic [31:0] rem_in, rem_next, sh;
        logic [15:0] den_in, q_in, q_next;
        if (g == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end else begin : g_more
            assign rem_in = rem_reg[g-1];
            assign den_in = den_reg[g-1];
            assign q_in   = q_reg[g-1];
        end
        always_comb begin
            rem_next = rem_in;
            q_next   = q_in;
            sh       = '0;
            for (int j = 0; j < 4; j++) begin
                sh = 32'(den_in) << (15 - (4 * g + j));
                if (rem_next >= sh) begin
                    rem_next = rem_next - sh;
                    q_next   = q_next | (16'd1 << (15 - (4 * g + j)));
                end
            end
        end
        if (g < 3) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[g] <= rem_next;
                    den_reg[g] <= den_in;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[g] <= q_next;
            end
        end
    end

    assign quot = q_reg[3];

endmodule

// File: rtl/chroma_key_matte.sv
// chroma_key_matte: soft chroma key matte, top level with config registers
// depends on ckm_pkg, ckm_ycc, ckm_sqrt and ckm_div
//
// Usage:
//   input channel s_valid/s_ready carries one rgb pixel per beat;
//   result channel m_valid/m_ready carries one 8-bit matte alpha per beat.
//   config channel cfg_valid/cfg_ready writes register cfg_index with cfg_data;
//   cfg_ready is always high, unknown indexes are dropped. write only while idle.
// Throughput: one pixel per cycle unless a stalled result holds the pipeline; the
//   pipeline is 18 register stages (color conversion 4, distance 2, square root 5,
//   setup 1, two parallel dividers 4, product 1, output 1), every stage takes a new pixel each cycle while not stalled.
// Reset: aresetn low clears all valid bits and loads default key (pure green)
//   and default spreads and tolerance; first pixel may be sent on the cycle after reset.
// Stall: when a result waits with m_ready low the whole pipeline holds and
//   s_ready drops; nothing is lost or repeated.
module chroma_key_matte (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_pixel_red,
    input  logic [7:0]       s_pixel_green,
    input  logic [7:0]       s_pixel_blue,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_matte_alpha,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  ckm_pkg::cfg_idx_t cfg_index,
    input  logic [10:0]      cfg_data
);
    import ckm_pkg::*;

    logic [7:0]  key_red_reg, key_green_reg, key_blue_reg;
    logic [10:0] chroma_spread_reg, chroma_tol_reg, luma_spread_reg;

    logic                en;
    logic [LATENCY-1:0]  vld_reg;

    logic [15:0]         p_luma, k_luma;
    logic signed [15:0]  p_cb, p_cr, k_cb, k_cr;

    logic signed [16:0]  dcb, dcr;
    logic signed [33:0]  sqcb_full, sqcr_full;
    logic [30:0]         sqcb_reg, sqcr_reg;
    logic [31:0]         sum_reg, sum_next;
    logic [15:0]         py_dly_reg [KEY_DLY];
    logic [15:0]         ky_dly_reg [KEY_DLY];
    logic [16:0]         root;

    logic [14:0]         s_val, l_val;
    logic [15:0]         t_val;
    logic [16:0]         st_sum, cdiff;
    logic signed [17:0]  lo, py_s;
    logic [17:0]         hi, gap;
    logic [15:0]         py, ky, up;
    fac_ctl_t            ctl_next, ctl_reg;
    logic [31:0]         cnum_next, lnum_next, cnum_reg, lnum_reg;
    logic [15:0]         cden_next, lden_next, cden_reg, lden_reg;
    fac_ctl_t            sel_dly_reg [SEL_DLY];
    logic [15:0]         cquot, lquot;

    logic [15:0]         fa, fy;
    logic [31:0]         fprod, fround;
    logic [15:0]         f_reg, f_next;
    logic [23:0]         afull;
    logic [7:0]          alpha_reg, alpha_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_red_reg       <= 8'd0;
            key_green_reg     <= 8'd255;
            key_blue_reg      <= 8'd0;
            chroma_spread_reg <= 11'd307;
            chroma_tol_reg    <= 11'd102;
            luma_spread_reg   <= 11'd307;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY_RED:    key_red_reg       <= cfg_data[7:0];
                REG_KEY_GREEN:  key_green_reg     <= cfg_data[7:0];
                REG_KEY_BLUE:   key_blue_reg      <= cfg_data[7:0];
                REG_CHROMA_SPR: chroma_spread_reg <= cfg_data;
                REG_CHROMA_TOL: chroma_tol_reg    <= cfg_data;
                REG_LUMA_SPR:   luma_spread_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // global advance, held only by a stalled output beat
    assign en      = !(vld_reg[LATENCY-1] && !m_ready);
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LATENCY-2:0], s_valid};
        end
    end

    // pixel and key color conversion in lockstep
    ckm_ycc u_pix_ycc (
        .aclk  (aclk),
        .en    (en),
        .red   (s_pixel_red),
        .green (s_pixel_green),
        .blue  (s_pixel_blue),
        .luma  (p_luma),
        .cb    (p_cb),
        .cr    (p_cr)
    );

    ckm_ycc u_key_ycc (
        .aclk  (aclk),
        .en    (en),
        .red   (key_red_reg),
        .green (key_green_reg),
        .blue  (key_blue_reg),
        .luma  (k_luma),
        .cb    (k_cb),
        .cr    (k_cr)
    );

    // chroma distance squared
    assign dcb       = $signed({p_cb[15], p_cb}) - $signed({k_cb[15], k_cb});
    assign dcr       = $signed({p_cr[15], p_cr}) - $signed({k_cr[15], k_cr});
    assign sqcb_full = dcb * dcb;
    assign sqcr_full = dcr * dcr;
    assign sum_next  = {1'b0, sqcb_reg} + {1'b0, sqcr_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            sqcb_reg      <= sqcb_full[30:0];
            sqcr_reg      <= sqcr_full[30:0];
            sum_reg       <= sum_next;
            py_dly_reg[0] <= p_luma;
            ky_dly_reg[0] <= k_luma;
            for (int i = 1; i < KEY_DLY; i++) begin
                py_dly_reg[i] <= py_dly_reg[i-1];
                ky_dly_reg[i] <= ky_dly_reg[i-1];
            end
        end
    end

    ckm_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (sum_reg),
        .root     (root)
    );

    // factor selection and divider operands
    assign py     = py_dly_reg[KEY_DLY-1];
    assign ky     = ky_dly_reg[KEY_DLY-1];
    assign s_val  = {chroma_spread_reg, 4'd0};
    assign t_val  = {chroma_tol_reg, 5'd0};
    assign l_val  = {luma_spread_reg, 4'd0};
    assign st_sum = {2'b00, s_val} + {1'b0, t_val};
    assign cdiff  = st_sum - root;
    assign lo     = $signed({2'b00, ky}) - $signed({3'b000, l_val});
    assign hi     = {2'b00, ky} + {3'b000, l_val};
    assign py_s   = $signed({2'b00, py});
    assign gap    = 18'd32768 - hi;
    assign up     = Q_ONE - py;

    always_comb begin
        ctl_next.chroma = FAC_ZERO;
        cnum_next       = '0;
        cden_next       = 16'd1;
        if (root < {2'b00, s_val}) begin
            ctl_next.chroma = FAC_FULL;
        end else if (t_val != 16'd0 && root < st_sum) begin
            ctl_next.chroma = FAC_RAMP;
            cnum_next       = {1'b0, cdiff[15:0], 15'd0} + {17'd0, t_val[15:1]};
            cden_next       = t_val;
        end
        ctl_next.luma = FAC_FULL;
        lnum_next     = '0;
        lden_next     = 16'd1;
        if (py_s < lo) begin
            ctl_next.luma = FAC_RAMP;
            lnum_next     = {1'b0, py, 15'd0} + {16'd0, lo[16:1]};
            lden_next     = lo[15:0];
        end else if ({2'b00, py} > hi) begin
            ctl_next.luma = FAC_RAMP;
            lnum_next     = {1'b0, up, 15'd0} + {16'd0, gap[16:1]};
            lden_next     = gap[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg        <= ctl_next;
            cnum_reg       <= cnum_next;
            cden_reg       <= cden_next;
            lnum_reg       <= lnum_next;
            lden_reg       <= lden_next;
            sel_dly_reg[0] <= ctl_reg;
            for (int i = 1; i < SEL_DLY; i++) begin
                sel_dly_reg[i] <= sel_dly_reg[i-1];
            end
        end
    end

    ckm_div u_chroma_div (
        .aclk (aclk),
        .en   (en),
        .num  (cnum_reg),
        .den  (cden_reg),
        .quot (cquot)
    );

    ckm_div u_luma_div (
        .aclk (aclk),
        .en   (en),
        .num  (lnum_reg),
        .den  (lden_reg),
        .quot (lquot)
    );

    // combine factors
    always_comb begin
        case (sel_dly_reg[SEL_DLY-1].chroma)
            FAC_FULL: fa = Q_ONE;
            FAC_RAMP: fa = cquot;
            default:  fa = 16'd0;
        endcase
        case (sel_dly_reg[SEL_DLY-1].luma)
            FAC_RAMP: fy = lquot;
            FAC_FULL: fy = Q_ONE;
            default:  fy = 16'd0;
        endcase
    end

    assign fprod  = 32'(fa) * 32'(fy);
    assign fround = fprod + 32'd16384;
    assign f_next = fround[30:15];

    // scale to 8 bits with rounding and clamp
    assign afull      = 24'(f_reg) * 24'd255 + 24'd16384;
    assign alpha_next = (afull[23:15] > 9'd255) ? 8'd255 : afull[22:15];

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg     <= f_next;
            alpha_reg <= alpha_next;
        end
    end

    assign m_valid       = vld_reg[LATENCY-1];
    assign m_matte_alpha = alpha_reg;

endmodule

// File: rtl/ckm_checker.sv
// ckm_checker: port-level assertions for chroma_key_matte
// no package dependency; bound to the top level at the end of this file
module ckm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_pixel_red,
    input logic [7:0]  s_pixel_green,
    input logic [7:0]  s_pixel_blue,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_matte_alpha,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [10:0] cfg_data
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_matte_alpha))
        else $error("stalled result beat changed");

    a_ready_only_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input blocked without an output stall");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind chroma_key_matte ckm_checker u_ckm_checker (.*);

// File: tb/tb_chroma_key_matte.sv
// tb_chroma_key_matte: self-checking bench for the chroma key matte block
// depends on ckm_pkg and chroma_key_matte; random pixels and key settings,
// alpha predicted in fixed point and compared beat by beat
`timescale 1ns / 100ps

module tb_chroma_key_matte;
    import ckm_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_pixel_red = '0, s_pixel_green = '0, s_pixel_blue = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_matte_alpha;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_idx_t cfg_index = REG_KEY_RED;
    logic [10:0] cfg_data = '0;

    chroma_key_matte DUT (.*);

    always #4 aclk = ~aclk;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    logic [7:0] key_r, key_g, key_b;
    logic [10:0] spread_c, tol_c, spread_y;

    pixel_t pixel_q[$];
    logic [7:0] alpha_q[$];
    int errors = 0;
    int n_checked = 0;
    int n_cfg = 0;
    bit hold_off = 1'b0;

    function automatic longint unsigned round_sqrt(longint unsigned v);
        longint unsigned res, bitv, n;
        res = 0;
        bitv = 64'd1 << 62;
        n = v;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        if (v - res * res > res) res++;
        return res;
    endfunction

    function automatic longint scale_q15(longint a, longint c);
        longint q;
        q = ((a < 0 ? -a : a) * c + 16384) >>> 15;
        return a < 0 ? -q : q;
    endfunction

    function automatic void rgb_to_ycc(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       output longint y, output longint cb,
                                       output longint cr);
        longint rn, bn;
        y = (longint'(CY_R) * r + longint'(CY_G) * g + longint'(CY_B) * b + 127) / 255;
        rn = (longint'(r) * 32768 + 127) / 255;
        bn = (longint'(b) * 32768 + 127) / 255;
        cb = scale_q15(bn - y, C_CB);
        cr = scale_q15(rn - y, C_CR);
    endfunction

    function automatic logic [7:0] key_alpha(pixel_t p);
        longint py, pcb, pcr, ky, kcb, kcr, dcb, dcr, d, s, t, l, lo, hi, fa, fy, f, a;
        rgb_to_ycc(p.r, p.g, p.b, py, pcb, pcr);
        rgb_to_ycc(key_r, key_g, key_b, ky, kcb, kcr);
        dcb = pcb - kcb;
        dcr = pcr - kcr;
        d = longint'(round_sqrt(dcb * dcb + dcr * dcr));
        s = longint'(spread_c) * 16;
        t = longint'(tol_c) * 32;
        l = longint'(spread_y) * 16;
        if (d < s) fa = 32768;
        else if (t > 0 && d < s + t) fa = ((s + t - d) * 32768 + t / 2) / t;
        else fa = 0;
        lo = ky - l;
        hi = ky + l;
        if (py < lo) fy = (py * 32768 + lo / 2) / lo;
        else if (py > hi) fy = ((32768 - py) * 32768 + (32768 - hi) / 2) / (32768 - hi);
        else fy = 32768;
        f = (fa * fy + 16384) >>> 15;
        a = (f * 255 + 16384) >>> 15;
        if (a > 255) a = 255;
        if (a < 0) a = 0;
        return a[7:0];
    endfunction

    // driver
    int gap_left = 0;
    bit in_taken = 1'b0;
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            alpha_q.push_back(key_alpha({s_pixel_red, s_pixel_green, s_pixel_blue}));
        end
    end

    always @(negedge aclk) begin
        if (!s_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (aresetn && pixel_q.size() > 0) begin
                pixel_t p;
                p = pixel_q.pop_front();
                s_valid <= 1'b1;
                {s_pixel_red, s_pixel_green, s_pixel_blue} <= p;
                gap_left <= ($urandom_range(0, 3) == 0) ?
                            (($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) :
                             $urandom_range(1, 2)) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    int stall_left = 0;
    always @(negedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) :
                              $urandom_range(1, 2);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (alpha_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %0d",
                         $time, m_matte_alpha);
                errors++;
            end else begin
                logic [7:0] want;
                want = alpha_q.pop_front();
                if (m_matte_alpha !== want) begin
                    $display("%0t: alpha mismatch, expected %0d, actual %0d",
                             $time, want, m_matte_alpha);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [10:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_KEY_RED:    key_r = val[7:0];
            REG_KEY_GREEN:  key_g = val[7:0];
            REG_KEY_BLUE:   key_b = val[7:0];
            REG_CHROMA_SPR: spread_c = val;
            REG_CHROMA_TOL: tol_c = val;
            REG_LUMA_SPR:   spread_y = val;
            default: ;
        endcase
        n_cfg++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || s_valid || alpha_q.size() > 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic pixel_t near_key(int spread);
        pixel_t p;
        p.r = 8'(int'(key_r) + $urandom_range(0, 2 * spread) - spread);
        p.g = 8'(int'(key_g) + $urandom_range(0, 2 * spread) - spread);
        p.b = 8'(int'(key_b) + $urandom_range(0, 2 * spread) - spread);
        return p;
    endfunction

    task automatic random_pixels(int n);
        repeat (n) begin
            if ($urandom_range(0, 1)) pixel_q.push_back(near_key($urandom_range(1, 40)));
            else pixel_q.push_back(pixel_t'(24'($urandom)));
        end
    endtask

    initial begin
        key_r = 0; key_g = 255; key_b = 0;
        spread_c = 307; tol_c = 102; spread_y = 307;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, key colour, primaries
        pixel_q.push_back('{8'd0, 8'd0, 8'd0});
        pixel_q.push_back('{8'd255, 8'd255, 8'd255});
        pixel_q.push_back('{8'd0, 8'd255, 8'd0});
        pixel_q.push_back('{8'd255, 8'd0, 8'd0});
        pixel_q.push_back('{8'd0, 8'd0, 8'd255});
        pixel_q.push_back('{8'd20, 8'd230, 8'd20});
        pixel_q.push_back('{8'd60, 8'd200, 8'd60});
        pixel_q.push_back('{8'd0, 8'd128, 8'd0});
        drain();

        // zero tolerance, oversized registers, unknown index
        write_reg(REG_CHROMA_TOL, 11'd0);
        write_reg(REG_CHROMA_SPR, 11'd2047);
        write_reg(REG_LUMA_SPR, 11'd2047);
        write_reg(cfg_idx_t'(6), 11'h5A5);
        write_reg(cfg_idx_t'(7), 11'h7FF);
        pixel_q.push_back('{8'd255, 8'd0, 8'd255});
        pixel_q.push_back('{8'd0, 8'd0, 8'd0});
        pixel_q.push_back('{8'd255, 8'd255, 8'd255});
        drain();
        write_reg(REG_CHROMA_SPR, 11'd0);
        write_reg(REG_LUMA_SPR, 11'd0);
        pixel_q.push_back('{8'd0, 8'd255, 8'd0});
        pixel_q.push_back('{8'd1, 8'd254, 8'd1});
        pixel_q.push_back('{8'd128, 8'd128, 8'd128});
        drain();
        write_reg(REG_KEY_RED, 11'd255);
        write_reg(REG_KEY_GREEN, 11'd255);
        write_reg(REG_KEY_BLUE, 11'd255);
        write_reg(REG_CHROMA_TOL, 11'd1024);
        pixel_q.push_back('{8'd255, 8'd255, 8'd255});
        pixel_q.push_back('{8'd200, 8'd200, 8'd200});
        pixel_q.push_back('{8'd0, 8'd0, 8'd0});
        drain();

        // long hold-off on the result side so the pipeline backs up
        hold_off = 1'b1;
        random_pixels(60);
        repeat (80) @(posedge aclk);
        hold_off = 1'b0;
        drain();

        // random phases with random key settings
        for (int ph = 0; ph < 12; ph++) begin
            int pick;
            pick = $urandom_range(0, 3);
            write_reg(REG_KEY_RED, 11'($urandom_range(0, 255)));
            write_reg(REG_KEY_GREEN, 11'($urandom_range(0, 255)));
            write_reg(REG_KEY_BLUE, 11'($urandom_range(0, 255)));
            write_reg(REG_CHROMA_SPR, pick == 0 ? 11'($urandom) : 11'($urandom_range(0, 1024)));
            write_reg(REG_CHROMA_TOL, pick == 1 ? 11'd0 :
                      (pick == 2 ? 11'($urandom) : 11'($urandom_range(0, 1024))));
            write_reg(REG_LUMA_SPR, pick == 3 ? 11'($urandom) : 11'($urandom_range(0, 1024)));
            random_pixels(135);
            drain();
        end

        $display("checked %0d alpha beats over %0d register writes", n_checked, n_cfg);
        $display("covered zero tolerance, oversized spreads, unknown indexes and a long stall");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #4ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
